>>> rtl/ssfb_pkg.sv
// Package for the seven-segment frame builder: transaction types, command byte
// constants, the segment table and the byte slot codes.
// No dependencies.
package ssfb_pkg;

  localparam int unsigned NumDigits = 4;
  localparam logic [15:0] RecipTen  = 16'hCCCD;
  localparam int unsigned RecipShift = 19;

  localparam logic [7:0] CmdModeAutoInc = 8'h40;
  localparam logic [7:0] CmdAddrFirst   = 8'hC0;
  localparam logic [7:0] CmdDisplayOff  = 8'h80;
  localparam logic [7:0] CmdCtrlBase    = 8'h87;
  localparam logic [3:0] MaxLevel       = 4'd8;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  brightness;
  } in_item_t;

  typedef struct packed {
    logic [7:0] command_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;
  } out_item_t;

  // One classified request: four decimal digits, thousands in the top nibble.
  typedef struct packed {
    logic [15:0] digits;
    logic [7:0]  ctrl;
  } entry_t;

  typedef enum logic [3:0] {
    SlotMode  = 4'd0,
    SlotAddr  = 4'd1,
    SlotDig3  = 4'd2,
    SlotDig2  = 4'd3,
    SlotDig1  = 4'd4,
    SlotDig0  = 4'd5,
    SlotPadA  = 4'd6,
    SlotPadB  = 4'd7,
    SlotCtrl  = 4'd8
  } slot_e;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'h3F;
      4'd1: code = 8'h06;
      4'd2: code = 8'h5B;
      4'd3: code = 8'h4F;
      4'd4: code = 8'h66;
      4'd5: code = 8'h6D;
      4'd6: code = 8'h7D;
      4'd7: code = 8'h07;
      4'd8: code = 8'h7F;
      4'd9: code = 8'h6F;
      default: code = 8'h3F;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/ssfb_front.sv
// Front end of the frame builder: accepts a request, splits the value into
// four decimal digits one per cycle and computes the control byte.
// Depends on ssfb_pkg.
module ssfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ssfb_pkg::in_item_t item_i,
  output logic              q_push_o,
  input  logic              q_full_i,
  output ssfb_pkg::entry_t  q_data_o
);
  import ssfb_pkg::*;

  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] val_q, val_d;
  logic [15:0] dig_q, dig_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [16:0] quot_ten;
  logic [15:0] rem_full;
  logic [3:0]  level;
  logic        accept;
  logic        done;

  assign prod     = 32'(val_q) * 32'(RecipTen);
  assign quot     = prod[31:RecipShift];
  assign quot_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign rem_full = val_q - quot_ten[15:0];
  assign level    = (item_i.brightness > MaxLevel) ? MaxLevel : item_i.brightness;

  assign accept   = push && !busy_q;
  assign done     = busy_q && (cnt_q == 3'(NumDigits));
  assign q_push_o = done && !q_full_i;
  assign full     = busy_q;
  assign q_data_o = '{digits: dig_q, ctrl: ctrl_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    dig_d  = dig_q;
    ctrl_d = ctrl_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      val_d  = item_i.value;
      ctrl_d = (level == 4'd0) ? CmdDisplayOff : (CmdCtrlBase + 8'(level));
    end else if (busy_q && !done) begin
      cnt_d = cnt_q + 3'd1;
      val_d = {3'b000, quot};
      dig_d = {rem_full[3:0], dig_q[15:4]};
    end else if (q_push_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    dig_q  <= dig_d;
    ctrl_q <= ctrl_d;
  end

endmodule

>>> rtl/ssfb_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on ssfb_pkg.
module ssfb_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  ssfb_pkg::entry_t data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output ssfb_pkg::entry_t data_o
);
  import ssfb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/ssfb_back.sv
// Back end of the frame builder: walks the nine byte slots of the head request
// and loads each command byte into the result register.
// Depends on ssfb_pkg.
module ssfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  ssfb_pkg::entry_t    q_data_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output ssfb_pkg::out_item_t result_o
);
  import ssfb_pkg::*;

  slot_e     slot_q, slot_d;
  logic      valid_q, valid_d;
  out_item_t res_q, res_d;
  logic      load;

  assign load     = !q_empty_i && (!valid_q || pop);
  assign q_pop_o  = load && (slot_q == SlotCtrl);
  assign empty    = !valid_q;
  assign result_o = res_q;

  always_comb begin
    res_d   = '{command_byte: 8'h00, frame_start: 1'b0, frame_end: 1'b0, last: 1'b0};
    slot_d  = slot_q;
    valid_d = valid_q;
    case (slot_q)
      SlotMode: begin
        res_d.command_byte = CmdModeAutoInc;
        res_d.frame_start  = 1'b1;
        res_d.frame_end    = 1'b1;
      end
      SlotAddr: begin
        res_d.command_byte = CmdAddrFirst;
        res_d.frame_start  = 1'b1;
      end
      SlotDig3: res_d.command_byte = seg_code(q_data_i.digits[15:12]);
      SlotDig2: res_d.command_byte = seg_code(q_data_i.digits[11:8]);
      SlotDig1: res_d.command_byte = seg_code(q_data_i.digits[7:4]);
      SlotDig0: res_d.command_byte = seg_code(q_data_i.digits[3:0]);
      SlotPadA: res_d.command_byte = seg_code(4'd0);
      SlotPadB: begin
        res_d.command_byte = seg_code(4'd0);
        res_d.frame_end    = 1'b1;
      end
      SlotCtrl: begin
        res_d.command_byte = q_data_i.ctrl;
        res_d.frame_start  = 1'b1;
        res_d.frame_end    = 1'b1;
        res_d.last         = 1'b1;
      end
      default: res_d.command_byte = 8'h00;
    endcase
    if (load) begin
      valid_d = 1'b1;
      slot_d  = (slot_q == SlotCtrl) ? SlotMode : slot_e'(slot_q + 4'd1);
    end else if (pop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SlotMode;
      valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

>>> rtl/seven_segment_frame_builder_unit.sv
// Top level of the seven-segment frame builder: front end, request queue and
// back end. Depends on ssfb_pkg, ssfb_front, ssfb_queue and ssfb_back.
//
//   Channel   Handshake        Payload    Accepted when
//   request   push / full      item_i     push high, full low
//   result    empty / pop      result_o   pop high, empty low
//
// Every request yields nine result transactions, one per cycle while pop is
// held, so the sustained rate is set by the back end.
// After each request the front end holds full through the extraction of the
// four digits (one digit per cycle through a reciprocal multiplier) and the
// push into the queue, and longer while the queue is full.
// Reset clears all control state; the queue starts empty and empty is high.
// A stalled result holds on result_o; the front end keeps accepting until the
// queue fills.
module seven_segment_frame_builder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ssfb_pkg::in_item_t  item_i,
  output logic                empty,
  input  logic                pop,
  output ssfb_pkg::out_item_t result_o
);
  import ssfb_pkg::*;

  entry_t f_data;
  entry_t b_data;
  logic   f_push;
  logic   q_full;
  logic   q_empty;
  logic   b_pop;

  ssfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .q_push_o (f_push),
    .q_full_i (q_full),
    .q_data_o (f_data)
  );

  ssfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .full_o  (q_full),
    .data_i  (f_data),
    .pop_i   (b_pop),
    .empty_o (q_empty),
    .data_o  (b_data)
  );

  ssfb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (b_data),
    .q_pop_o   (b_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

>>> rtl/ssfb_checker.sv
// Port-level checks for the seven-segment frame builder, bound to the top level.
// Depends on ssfb_pkg and seven_segment_frame_builder_unit.
module ssfb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input ssfb_pkg::in_item_t  item_i,
  input logic                empty,
  input logic                pop,
  input ssfb_pkg::out_item_t result_o
);
  import ssfb_pkg::*;

  // A stalled result transaction stays on the ports unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("stalled result changed");

  // The final byte of a request is a control byte framed on both sides.
  a_last_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.last |->
      result_o.command_byte[7] && result_o.frame_start && result_o.frame_end)
    else $error("last byte is not a framed control byte");

  // The mode byte is a frame of its own and never ends a request.
  a_mode_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.frame_start && (result_o.command_byte == CmdModeAutoInc) |->
      result_o.frame_end && !result_o.last)
    else $error("mode byte framing wrong");

  // After the address byte is taken, the first digit follows at once.
  a_addr_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && result_o.frame_start && (result_o.command_byte == CmdAddrFirst)
      |=> !empty && !result_o.frame_start && !result_o.last)
    else $error("digit did not follow address byte");

endmodule

bind seven_segment_frame_builder_unit ssfb_checker u_ssfb_checker (.*);
